### design/assert_macros.svh
// Assertion helpers for the design files; the top-level parser uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ICP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("icp check failed");

// Next-cycle implication, masked during reset.
`define ICP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("icp check failed");

`endif

### design/icp_pkg.sv
package icp_pkg;

  typedef enum logic [2:0] {
    PH_ADDR_LEAD  = 3'd0,
    PH_ADDR_BODY  = 3'd1,
    PH_ADDR_TRAIL = 3'd2,
    PH_PFX_LEAD   = 3'd3,
    PH_PFX_DIGITS = 3'd4,
    PH_PFX_TRAIL  = 3'd5
  } phase_t;

  localparam logic [7:0]  CH_NUL   = 8'h00;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_DOT   = 8'h2e;
  localparam logic [7:0]  CH_SLASH = 8'h2f;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;

  localparam logic [3:0]  LOCAL_NAME_LEN = 4'd9;
  localparam logic [31:0] LOCAL_ADDR     = (32'd127 << 24) | 32'h1;

  localparam logic [8:0]  OCT_MAX  = 9'd255;
  localparam logic [8:0]  OCT_SAT  = 9'd256;
  localparam logic [2:0]  SEP_SAT  = 3'd5;
  localparam logic [2:0]  SEP_FULL = 3'd4;
  localparam logic [5:0]  PFX_MAX  = 6'd32;
  localparam logic [5:0]  PFX_SAT  = 6'd33;
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] address;
    logic [31:0] net_mask;
    logic [5:0]  prefix_len;
    logic        has_prefix;
  } res_t;

  // Characters of "localhost" by position.
  function automatic logic [7:0] local_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0: c = 8'h6c;
      4'd1: c = 8'h6f;
      4'd2: c = 8'h63;
      4'd3: c = 8'h61;
      4'd4: c = 8'h6c;
      4'd5: c = 8'h68;
      4'd6: c = 8'h6f;
      4'd7: c = 8'h73;
      4'd8: c = 8'h74;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

### design/icp_if.sv
interface icp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface icp_res_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [31:0] address;
  logic [31:0] net_mask;
  logic [5:0]  prefix_len;
  logic        has_prefix;

  modport source (output valid, output valid_res, output address, output net_mask,
                  output prefix_len, output has_prefix, input ready);
  modport sink   (input valid, input valid_res, input address, input net_mask,
                  input prefix_len, input has_prefix, output ready);
endinterface

### design/ipv4_cidr_text_parser.sv
// A terminating zero byte passes through the input register, then the parse
// logic into the result register.
// Throughput: one byte per cycle; only a zero byte waits, and only while the
// result register still holds a result that has not been taken.
// Reset (rst, synchronous, active high) empties both registers and returns the
// parser to the start of a string.
`include "assert_macros.svh"

module ipv4_cidr_text_parser
  import icp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  icp_byte_if.sink  text,
  icp_res_if.source result
);

  // Input register: one byte per item.
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Advance control. Ordinary characters only update the parse state and
  // always move on; a zero byte also writes the result register, so it
  // waits until that register is free.
  logic s1_end;
  logic s1_go;
  logic out_free;
  res_t core_res;

  assign s1_end     = (s1_byte == CH_NUL);
  assign s1_go      = s1_valid && (!s1_end || out_free);
  assign text.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      s1_byte <= text.text_byte;
    end
  end

  // Parse state and result formation.
  icp_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (s1_go),
    .ch   (s1_byte),
    .res  (core_res)
  );

  // Result register toward the sink.
  icp_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (s1_go && s1_end),
    .res    (core_res),
    .free   (out_free),
    .result (result)
  );

  // A string end that moves on must show up as a result in the next cycle.
  `ICP_ASSERT_NEXT(a_end_gives_result, s1_go && s1_end, result.valid)
  // A rejected string carries all-zero fields.
  `ICP_ASSERT_NOW(a_invalid_zero, result.valid && !result.valid_res,
    result.address == 32'd0 && result.net_mask == 32'd0 &&
    result.prefix_len == 6'd0 && !result.has_prefix)
  // An accepted prefix never exceeds 32, and no slash means no mask.
  `ICP_ASSERT_NOW(a_prefix_range, result.valid && result.valid_res,
    result.prefix_len <= PFX_MAX && (result.has_prefix || result.net_mask == 32'd0))
  // The mask always matches the prefix length.
  `ICP_ASSERT_NOW(a_mask_len, result.valid && result.valid_res,
    result.net_mask == ~(ALL_ONES >> result.prefix_len))

endmodule

### design/icp_core.sv
module icp_core
  import icp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] ch,
  output res_t       res
);

  phase_t      phase, phase_next;
  logic [8:0]  octet_acc, octet_acc_next;
  logic [2:0]  sep_count, sep_count_next;
  logic [31:0] addr_shift, addr_shift_next;
  logic [3:0]  name_pos, name_pos_next;
  logic        name_ok, name_ok_next;
  logic        addr_bad, addr_bad_next;
  logic [5:0]  prefix_acc, prefix_acc_next;
  logic        prefix_bad, prefix_bad_next;

  logic        is_space, is_dot, is_slash, is_digit;
  logic [3:0]  dval;
  logic [11:0] oct_prod;
  logic [8:0]  oct_new;
  logic [8:0]  pfx_prod;
  logic [5:0]  pfx_new;
  logic        name_hit;

  logic [2:0]  sep_e;
  logic        bad_e;
  logic [31:0] shift_e;
  logic        early, is_local;
  logic [2:0]  fin_sep;
  logic [31:0] fin_shift;
  logic        fin_bad;
  logic [8:0]  fin_oct;
  logic [5:0]  pfx_bits;
  res_t        raw;

  assign is_space = (ch == CH_SPACE);
  assign is_dot   = (ch == CH_DOT);
  assign is_slash = (ch == CH_SLASH);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dval     = 4'(ch - CH_ZERO);

  // decimal accumulate, saturating one past the legal maximum
  assign oct_prod = 12'(octet_acc) * 12'd10 + 12'(dval);
  assign oct_new  = (oct_prod > 12'(OCT_MAX)) ? OCT_SAT : oct_prod[8:0];
  assign pfx_prod = 9'(prefix_acc) * 9'd10 + 9'(dval);
  assign pfx_new  = (pfx_prod > 9'(PFX_MAX)) ? PFX_SAT : pfx_prod[5:0];

  assign name_hit = name_ok && (name_pos < LOCAL_NAME_LEN) && (ch == local_char(name_pos));

  // close the current octet
  assign sep_e   = (sep_count < SEP_SAT) ? sep_count + 3'd1 : sep_count;
  assign bad_e   = addr_bad || (sep_e > SEP_FULL) || (octet_acc > OCT_MAX);
  assign shift_e = {addr_shift[23:0], octet_acc[7:0]};

  // end of the address part
  assign early     = (phase == PH_ADDR_LEAD) || (phase == PH_ADDR_BODY);
  assign is_local  = name_ok && (name_pos == LOCAL_NAME_LEN);
  assign fin_sep   = early ? sep_e : sep_count;
  assign fin_oct   = early ? 9'd0 : octet_acc;
  assign fin_shift = is_local ? LOCAL_ADDR : (early ? shift_e : addr_shift);
  assign fin_bad   = is_local ? 1'b0 : ((early ? bad_e : addr_bad) || (fin_sep != SEP_FULL));

  always_comb begin
    phase_next      = phase;
    octet_acc_next  = octet_acc;
    sep_count_next  = sep_count;
    addr_shift_next = addr_shift;
    name_pos_next   = name_pos;
    name_ok_next    = name_ok;
    addr_bad_next   = addr_bad;
    prefix_acc_next = prefix_acc;
    prefix_bad_next = prefix_bad;
    if (step) begin
      if (ch == CH_NUL) begin
        phase_next      = PH_ADDR_LEAD;
        octet_acc_next  = '0;
        sep_count_next  = '0;
        addr_shift_next = '0;
        name_pos_next   = '0;
        name_ok_next    = 1'b1;
        addr_bad_next   = 1'b0;
        prefix_acc_next = '0;
        prefix_bad_next = 1'b0;
      end else begin
        case (phase)
          PH_ADDR_LEAD, PH_ADDR_BODY, PH_ADDR_TRAIL: begin
            if (is_slash) begin
              sep_count_next  = fin_sep;
              octet_acc_next  = fin_oct;
              addr_shift_next = fin_shift;
              addr_bad_next   = fin_bad;
              phase_next      = PH_PFX_LEAD;
            end else begin
              if (name_hit) begin
                name_pos_next = name_pos + 4'd1;
              end else begin
                name_ok_next = 1'b0;
              end
              if (phase == PH_ADDR_LEAD && is_space) begin
                phase_next = phase;
              end else if (phase == PH_ADDR_TRAIL) begin
                if (!is_space) begin
                  addr_bad_next = 1'b1;
                end
              end else begin
                phase_next = PH_ADDR_BODY;
                if (!addr_bad) begin
                  if (is_dot || is_space) begin
                    sep_count_next  = sep_e;
                    addr_bad_next   = bad_e;
                    addr_shift_next = shift_e;
                    octet_acc_next  = '0;
                    if (is_space) begin
                      phase_next = PH_ADDR_TRAIL;
                    end
                  end else if (is_digit) begin
                    octet_acc_next = oct_new;
                  end else begin
                    addr_bad_next = 1'b1;
                  end
                end
              end
            end
          end
          PH_PFX_LEAD: begin
            if (!prefix_bad && !is_space) begin
              phase_next = PH_PFX_DIGITS;
              if (is_digit) begin
                prefix_acc_next = pfx_new;
              end else begin
                prefix_bad_next = 1'b1;
              end
            end
          end
          PH_PFX_DIGITS: begin
            if (!prefix_bad) begin
              if (is_digit) begin
                prefix_acc_next = pfx_new;
              end else if (is_space) begin
                phase_next = PH_PFX_TRAIL;
              end else begin
                prefix_bad_next = 1'b1;
              end
            end
          end
          PH_PFX_TRAIL: begin
            if (!prefix_bad && !is_space) begin
              prefix_bad_next = 1'b1;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  // result for a terminating byte, taken from the state before it
  assign pfx_bits = prefix_bad ? 6'd0 : prefix_acc;

  always_comb begin
    raw = '0;
    case (phase)
      PH_ADDR_LEAD, PH_ADDR_BODY, PH_ADDR_TRAIL: begin
        raw.valid_res = !fin_bad;
        raw.address   = fin_shift;
      end
      PH_PFX_LEAD, PH_PFX_DIGITS, PH_PFX_TRAIL: begin
        raw.valid_res  = !addr_bad && (pfx_bits <= PFX_MAX);
        raw.address    = addr_shift;
        raw.net_mask   = ~(ALL_ONES >> pfx_bits);
        raw.prefix_len = pfx_bits;
        raw.has_prefix = 1'b1;
      end
      default: begin
        raw.valid_res = 1'b0;
      end
    endcase
    res = raw.valid_res ? raw : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_ADDR_LEAD;
      octet_acc  <= '0;
      sep_count  <= '0;
      addr_shift <= '0;
      name_pos   <= '0;
      name_ok    <= 1'b1;
      addr_bad   <= 1'b0;
      prefix_acc <= '0;
      prefix_bad <= 1'b0;
    end else begin
      phase      <= phase_next;
      octet_acc  <= octet_acc_next;
      sep_count  <= sep_count_next;
      addr_shift <= addr_shift_next;
      name_pos   <= name_pos_next;
      name_ok    <= name_ok_next;
      addr_bad   <= addr_bad_next;
      prefix_acc <= prefix_acc_next;
      prefix_bad <= prefix_bad_next;
    end
  end

endmodule

### design/icp_out_reg.sv
module icp_out_reg
  import icp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  res_t      res,
  output logic      free,
  icp_res_if.source result
);

  logic valid;
  res_t data;

  assign free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data <= res;
    end
  end

  assign result.valid      = valid;
  assign result.valid_res  = data.valid_res;
  assign result.address    = data.address;
  assign result.net_mask   = data.net_mask;
  assign result.prefix_len = data.prefix_len;
  assign result.has_prefix = data.has_prefix;

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import icp_pkg::*;

  // Long receiver hold-off; it lets the result register and the input
  // register fill so that the parser stalls its input.
  localparam int HOLD_CYCLES = 400;
  // The mixed random part runs in two stretches, up to the first and then
  // the second figure; the whole run stops after the third figure in total.
  localparam int MIX_FIRST_BYTES = 750;
  localparam int MIX_BYTES       = 1250;
  localparam int TOTAL_BYTES     = 1750;
  // "localhost", first character in the top byte.
  localparam logic [71:0] HOST_NAME = "localhost";
  // Characters for noise strings that still touch the parser's phases.
  localparam string NOISE_CHARS = " ./0123456789localhstx";

  typedef enum logic [1:0] {
    SINK_BURSTY,
    SINK_HOLD,
    SINK_OPEN
  } sink_mode_t;

  logic clk = 1'b0;
  logic rst;

  icp_byte_if byte_if ();
  icp_res_if  res_if ();

  ipv4_cidr_text_parser i_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (byte_if),
    .result (res_if)
  );

  always #10 clk = ~clk;

  // Predicted results, oldest first.
  res_t expected_parses[$];

  sink_mode_t sink_mode = SINK_BURSTY;
  bit         src_idle_on;
  int         bytes_sent;
  int         mismatches;

  // ---------------------------------------------------------------------
  // Parser state as the predictor sees it.
  // ---------------------------------------------------------------------
  phase_t      parse_phase;
  logic [8:0]  octet_val;    // saturates at OCT_SAT
  logic [2:0]  octets_done;  // saturates at SEP_SAT
  logic [31:0] addr_bits;
  logic [3:0]  host_pos;     // characters of the host name matched
  logic        host_ok;      // text so far is still a prefix of the name
  logic        addr_err;
  logic [5:0]  pfx_val;      // saturates at PFX_SAT
  logic        pfx_err;      // prefix text not numeric, reads as 0

  function automatic void parser_clear();
    parse_phase = PH_ADDR_LEAD;
    octet_val   = '0;
    octets_done = '0;
    addr_bits   = '0;
    host_pos    = '0;
    host_ok     = 1'b1;
    addr_err    = 1'b0;
    pfx_val     = '0;
    pfx_err     = 1'b0;
  endfunction

  function automatic void close_octet();
    if (octets_done < SEP_SAT) octets_done++;
    if (octets_done > SEP_FULL || octet_val > OCT_MAX) addr_err = 1'b1;
    addr_bits = {addr_bits[23:0], octet_val[7:0]};
    octet_val = '0;
  endfunction

  function automatic void addr_char(logic [7:0] c);
    int acc;
    if (host_ok && host_pos < LOCAL_NAME_LEN &&
        c == HOST_NAME[8 * (8 - int'(host_pos)) +: 8])
      host_pos++;
    else
      host_ok = 1'b0;

    if (parse_phase == PH_ADDR_LEAD && c == CH_SPACE) return;
    // after the ending space only spaces may follow
    if (parse_phase == PH_ADDR_TRAIL) begin
      if (c != CH_SPACE) addr_err = 1'b1;
      return;
    end
    parse_phase = PH_ADDR_BODY;
    if (addr_err) return;
    if (c == CH_DOT) begin
      close_octet();
    end else if (c == CH_SPACE) begin
      close_octet();
      parse_phase = PH_ADDR_TRAIL;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      acc = int'(octet_val) * 10 + int'(c) - int'(CH_ZERO);
      octet_val = (acc > int'(OCT_MAX)) ? OCT_SAT : acc[8:0];
    end else begin
      addr_err = 1'b1;
    end
  endfunction

  // Address part is over: at a slash or at the end of the string.
  function automatic void close_address();
    logic is_host;
    is_host = host_ok && host_pos == LOCAL_NAME_LEN;
    if (parse_phase <= PH_ADDR_BODY) close_octet();
    if (is_host) begin
      addr_bits = LOCAL_ADDR;
      addr_err  = 1'b0;
    end else if (octets_done != SEP_FULL) begin
      addr_err = 1'b1;
    end
  endfunction

  function automatic void pfx_char(logic [7:0] c);
    int acc;
    if (pfx_err) return;
    if (parse_phase == PH_PFX_LEAD) begin
      if (c == CH_SPACE) return;
      parse_phase = PH_PFX_DIGITS;
    end
    if (parse_phase == PH_PFX_DIGITS) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        acc = int'(pfx_val) * 10 + int'(c) - int'(CH_ZERO);
        pfx_val = (acc > int'(PFX_MAX)) ? PFX_SAT : acc[5:0];
      end else if (c == CH_SPACE) begin
        parse_phase = PH_PFX_TRAIL;
      end else begin
        pfx_err = 1'b1;
      end
    end else if (c != CH_SPACE) begin
      pfx_err = 1'b1;
    end
  endfunction

  // One accepted byte; a zero byte yields the expected result.
  function automatic void parse_char(logic [7:0] c);
    res_t       r;
    logic [5:0] bits;
    if (c != CH_NUL) begin
      if (parse_phase <= PH_ADDR_TRAIL) begin
        if (c == CH_SLASH) begin
          close_address();
          parse_phase = PH_PFX_LEAD;
        end else begin
          addr_char(c);
        end
      end else begin
        pfx_char(c);
      end
      return;
    end

    // an invalid string leaves every field at zero
    r = '0;
    if (parse_phase <= PH_ADDR_TRAIL) begin
      close_address();
      if (!addr_err) begin
        r.valid_res = 1'b1;
        r.address   = addr_bits;
      end
    end else begin
      bits = pfx_err ? 6'd0 : pfx_val;
      if (!addr_err && bits <= PFX_MAX) begin
        r.valid_res  = 1'b1;
        r.address    = addr_bits;
        r.prefix_len = bits;
        r.has_prefix = 1'b1;
        if (bits != 0) r.net_mask = ALL_ONES << (32 - int'(bits));
      end
    end
    expected_parses = {expected_parses, r};
    parser_clear();
  endfunction

  // ---------------------------------------------------------------------
  // Sender side. valid stays high between back-to-back items; it is only
  // lowered by an idle burst or a drain.
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    byte_if.valid     <= 1'b1;
    byte_if.text_byte <= b;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    parse_char(b);
    bytes_sent++;
    if (src_idle_on && $urandom_range(0, 9) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_NUL);
  endtask

  // Stop offering items until every predicted result has been taken.
  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_parses.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed address / CIDR text with random content, with
  // a few broken octet counts, oversized numbers and corrupted bytes.
  task automatic make_cidr_text(output string s);
    int n_oct;
    int k;
    s = "";
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) s = {s, " "};
    case ($urandom_range(0, 19))
      0, 1: s = {s, "localhost"};
      2:    s = {s, "local"};
      default: begin
        case ($urandom_range(0, 9))
          0:       n_oct = 3;
          1:       n_oct = 5;
          default: n_oct = 4;
        endcase
        for (int i = 0; i < n_oct; i++) begin
          if (i > 0) s = {s, "."};
          case ($urandom_range(0, 15))
            0:       ;  // empty octet
            1:       s = {s, $sformatf("%0d", $urandom_range(256, 999))};
            2:       s = {s, $sformatf("000%0d", $urandom_range(0, 99999999))};
            3:       s = {s, ($urandom_range(0, 1) != 0) ? "255" : "0"};
            default: s = {s, $sformatf("%0d", $urandom_range(0, 255))};
          endcase
        end
      end
    endcase
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) s = {s, " "};
    if ($urandom_range(0, 9) < 7) begin
      s = {s, "/"};
      if ($urandom_range(0, 3) == 0) s = {s, "  "};
      case ($urandom_range(0, 9))
        0:       s = {s, $sformatf("%0d", $urandom_range(33, 99999))};
        1:       ;  // empty prefix
        2:       s = {s, $sformatf("x%0d", $urandom_range(0, 32))};
        default: s = {s, $sformatf("%0d", $urandom_range(0, 32))};
      endcase
      if ($urandom_range(0, 3) == 0) s = {s, " "};
    end
    // corrupt one byte now and then
    if (s.len() > 0 && $urandom_range(0, 6) == 0) begin
      k = $urandom_range(0, s.len() - 1);
      s[k] = 8'($urandom_range(1, 255));
    end
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1) != 0) begin
      // any nonzero byte
      repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(1, 12))
        send_byte(NOISE_CHARS[$urandom_range(0, NOISE_CHARS.len() - 1)]);
    end
    send_byte(CH_NUL);
  endtask

  task automatic send_random_string();
    string s;
    if ($urandom_range(0, 9) < 2) begin
      send_noise();
    end else begin
      make_cidr_text(s);
      send_text(s);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    send_text("0.0.0.0");
    send_text("255.255.255.255");
    send_text("256.1.1.1");                 // octet over range
    send_text("999999999.1.1.1");           // octet accumulator saturates
    send_text("1.2.3.4/0");                 // zero prefix, mask 0
    send_text("1.2.3.4/32");
    send_text("1.2.3.4/33");                // prefix over range
    send_text("1.2.3.4/99999");             // prefix accumulator saturates
    send_text("1.2.3.4/ab99999");           // non-numeric prefix reads 0
    send_text("1.2.3.4/12/5");              // second slash
    send_text("1.2.3.4/");                  // empty prefix
    send_text("10.0.0.1/24");
    send_text("localhost");
    send_text("localhost/8");
    send_text("localhos");
    send_text("localhostx");
    send_text("  192.168.1.1 /  16  ");
    send_text("1..2.3");                    // empty octet counts as 0
    send_text("1.2.3.4.5");                 // more than four octets
    send_text("1.2.3");
    send_text("1.2.3.4 x");                 // junk after ending space
    send_text("1.2.3.4/ 1 2");              // digit after prefix trailer
    send_text("");
    send_text("/24");
    send_text("a.b.c.d");
  endtask

  // Random strings with idling on both sides; one full drain in the middle.
  task automatic test_random_mix(input int stop_at);
    bit paused;
    int half_way;
    paused   = 1'b0;
    half_way = bytes_sent + (stop_at - bytes_sent) / 2;
    while (bytes_sent < stop_at) begin
      send_random_string();
      if (!paused && bytes_sent > half_way) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // Receiver holds off; the sender keeps offering until the parser stalls.
  task automatic test_backpressure();
    string s;
    src_idle_on = 1'b0;
    sink_mode  <= SINK_HOLD;
    repeat (12) begin
      make_cidr_text(s);
      send_text(s);
    end
    wait_drained();
    sink_mode  <= SINK_BURSTY;
    src_idle_on = 1'b1;
  endtask

  // Last part: full rate on both sides.
  task automatic test_streaming();
    src_idle_on = 1'b0;
    sink_mode  <= SINK_OPEN;
    while (bytes_sent < TOTAL_BYTES) send_random_string();
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random not-ready bursts, a counted long hold, or always ready.
  // ---------------------------------------------------------------------
  initial begin
    int gap_left;
    int hold_count;
    res_if.ready = 1'b0;
    gap_left     = 0;
    hold_count   = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_if.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_HOLD: begin
            res_if.ready <= (hold_count >= HOLD_CYCLES);
            if (hold_count < HOLD_CYCLES) hold_count++;
          end
          SINK_OPEN: begin
            res_if.ready <= 1'b1;
            hold_count = 0;
          end
          default: begin
            hold_count = 0;
            if (gap_left != 0) begin
              res_if.ready <= 1'b0;
              gap_left--;
            end else if ($urandom_range(0, 7) == 0) begin
              res_if.ready <= 1'b0;
              gap_left = $urandom_range(0, 15);
            end else begin
              res_if.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_parses.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none actual %b %h %h %0d %b",
                 $time, res_if.valid_res, res_if.address, res_if.net_mask,
                 res_if.prefix_len, res_if.has_prefix);
      end else begin
        want = expected_parses.pop_front();
        check_field("valid_res", 32'(want.valid_res), 32'(res_if.valid_res));
        check_field("address", want.address, res_if.address);
        check_field("net_mask", want.net_mask, res_if.net_mask);
        check_field("prefix_len", 32'(want.prefix_len), 32'(res_if.prefix_len));
        check_field("has_prefix", 32'(want.has_prefix), 32'(res_if.has_prefix));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    byte_if.valid     = 1'b0;
    byte_if.text_byte = CH_NUL;
    src_idle_on       = 1'b1;
    bytes_sent        = 0;
    mismatches        = 0;
    parser_clear();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix(MIX_FIRST_BYTES);
    test_backpressure();
    test_random_mix(MIX_BYTES);
    test_streaming();

    wait_drained();
    // let the clock run on to catch any stray result
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("ipv4_cidr_text_parser verification clean");
    else
      $display("ipv4_cidr_text_parser verification failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("ipv4_cidr_text_parser verification failed");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/icp_pkg.sv
design/icp_if.sv
design/icp_core.sv
design/icp_out_reg.sv
design/ipv4_cidr_text_parser.sv
bench/tb_top.sv
